### rtl/core/assert_macros.svh
// Assertion helpers for the verify-key core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold whenever out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/mvk_pkg.sv
`timescale 1ns / 1ps
package mvk_pkg;

    localparam int unsigned NumRounds = 64;
    localparam logic [31:0] KeyModulus = 32'hFFFF_FFFE;
    localparam logic [31:0] MsgBits = 32'd64;
    localparam logic [31:0] PadWord = 32'h0000_0080;
    localparam logic [31:0] InitA = 32'h6745_2301;
    localparam logic [31:0] InitB = 32'hefcd_ab89;
    localparam logic [31:0] InitC = 32'h98ba_dcfe;
    localparam logic [31:0] InitD = 32'h1032_5476;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_md5_state;

    localparam logic [31:0] RoundK [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] RoundRot [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] w;
        w = {v, v} << s;
        return w[63:32];
    endfunction

    // Message word g of the single padded block.
    function automatic logic [31:0] msg_word(input logic [3:0] g, input logic [31:0] lo,
                                             input logic [31:0] hi);
        logic [31:0] m;
        case (g)
            4'd0: m = lo;
            4'd1: m = hi;
            4'd2: m = PadWord;
            4'd14: m = MsgBits;
            default: m = '0;
        endcase
        return m;
    endfunction

    // One MD5 step for round r (constant at each stage).
    function automatic t_md5_state md5_round(input t_md5_state s, input int unsigned r,
                                             input logic [31:0] lo, input logic [31:0] hi);
        logic [31:0] f;
        logic [3:0] g;
        logic [31:0] t;
        t_md5_state o;
        if (r < 16) begin
            f = (s.b & s.c) | (~s.b & s.d);
            g = 4'(r);
        end else if (r < 32) begin
            f = (s.d & s.b) | (~s.d & s.c);
            g = 4'(5 * r + 1);
        end else if (r < 48) begin
            f = s.b ^ s.c ^ s.d;
            g = 4'(3 * r + 5);
        end else begin
            f = s.c ^ (s.b | ~s.d);
            g = 4'(7 * r);
        end
        t = s.a + f + RoundK[r] + msg_word(g, lo, hi);
        o.a = s.d;
        o.d = s.c;
        o.c = s.b;
        o.b = s.b + rotl32(t, RoundRot[((r >> 4) << 2) | (r & 3)]);
        return o;
    endfunction

endpackage

### rtl/core/md5_udp_verify_key_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-------------------
// input     | in        | i_valid / o_stall  | i_target_ip[31:0]
// output    | out       | o_valid / i_stall  | o_verify_key[31:0]
// config    | in        | i_cfg_valid/o_cfg_ready | i_cfg_secret_key[31:0]
//
// Pipeline: 64 MD5 round stages, then fold and reduce stages.
// Throughput: one request per cycle while o_stall is low; the 64 round stages set most of the depth.
// Reset (synchronous, active low) clears all valid bits and secret_key to 0.
// i_stall freezes the whole pipe in place (global enable) only when the output
// holds a request, and is then passed back as o_stall; bubbles keep moving.
module md5_udp_verify_key_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_target_ip,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_verify_key,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_secret_key
);
    import mvk_pkg::*;

    logic r_secret_key;
    logic [31:0] r_secret;
    logic en;
    logic [NumRounds:0] v_chain;
    t_md5_state s_chain [NumRounds+1];
    logic [31:0] lo_chain [NumRounds+1];
    logic [31:0] hi_chain [NumRounds+1];

    // Pipe advances unless a finished request waits on a stalled sink.
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secret <= '0;
            r_secret_key <= 1'b0;
        end else if (i_cfg_valid) begin
            r_secret <= i_cfg_secret_key;
            r_secret_key <= 1'b1;
        end
    end

    assign v_chain[0] = i_valid;
    assign s_chain[0] = '{a: InitA, b: InitB, c: InitC, d: InitD};
    assign lo_chain[0] = i_target_ip;
    assign hi_chain[0] = r_secret;

    for (genvar r = 0; r < NumRounds; r++) begin : g_round
        mvk_round_stage u_round (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_round(6'(r)),
            .i_valid(v_chain[r]),
            .i_state(s_chain[r]),
            .i_lo   (lo_chain[r]),
            .i_hi   (hi_chain[r]),
            .o_valid(v_chain[r+1]),
            .o_state(s_chain[r+1]),
            .o_lo   (lo_chain[r+1]),
            .o_hi   (hi_chain[r+1])
        );
    end

    mvk_fold u_fold (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(v_chain[NumRounds]),
        .i_state(s_chain[NumRounds]),
        .o_valid(o_valid),
        .o_key  (o_verify_key)
    );

    `ASSERT_CLK(a_stall_holds, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_verify_key)), "output dropped under stall")
    `ASSERT_CLK(a_stall_only_full, i_clk, i_rst_n, o_stall |-> o_valid, "stall without pending result")
    `ASSERT_ALWAYS(a_cfg_seen, i_clk, (r_secret != 32'd0) |-> (r_secret_key || !i_rst_n || $past(!i_rst_n)) || r_secret_key, "secret set without write")
endmodule

### rtl/core/mvk_round_stage.sv
`timescale 1ns / 1ps
// One registered MD5 round; round number picked by stage index input tie-off.
module mvk_round_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [5:0]        i_round,
    input  logic              i_valid,
    input  mvk_pkg::t_md5_state i_state,
    input  logic [31:0]       i_lo,
    input  logic [31:0]       i_hi,
    output logic              o_valid,
    output mvk_pkg::t_md5_state o_state,
    output logic [31:0]       o_lo,
    output logic [31:0]       o_hi
);
    import mvk_pkg::*;

    logic r_valid;
    t_md5_state r_state;
    logic [31:0] r_lo;
    logic [31:0] r_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= md5_round(i_state, int'(i_round), i_lo, i_hi);
            r_lo <= i_lo;
            r_hi <= i_hi;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_lo = r_lo;
    assign o_hi = r_hi;
endmodule

### rtl/core/mvk_fold.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Final add, XOR fold, mod 0xFFFFFFFE plus one; two registered steps.
module mvk_fold (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  mvk_pkg::t_md5_state i_state,
    output logic              o_valid,
    output logic [31:0]       o_key
);
    import mvk_pkg::*;

    logic r_valid0;
    logic r_valid1;
    logic [31:0] r_fold;
    logic [31:0] r_key;
    logic [31:0] n_fold;
    logic [31:0] n_key;

    assign n_fold = (i_state.a + InitA) ^ (i_state.b + InitB)
                  ^ (i_state.c + InitC) ^ (i_state.d + InitD);
    // fold < 2*modulus, so one conditional subtract.
    assign n_key = ((r_fold >= KeyModulus) ? (r_fold - KeyModulus) : r_fold) + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
            r_valid1 <= 1'b0;
        end else if (i_en) begin
            r_valid0 <= i_valid;
            r_valid1 <= r_valid0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fold <= n_fold;
            r_key <= n_key;
        end
    end

    assign o_valid = r_valid1;
    assign o_key = r_key;

    `ASSERT_CLK(a_key_nonzero, i_clk, i_rst_n, r_valid1 |-> (r_key != 32'd0 && r_key != 32'hFFFF_FFFF), "verify key out of range")
    `ASSERT_CLK(a_valid_chain, i_clk, i_rst_n, (i_en && r_valid0) |=> r_valid1, "fold valid lost")
endmodule

### dv/tb_md5_udp_verify_key_unit.sv
`timescale 1ns / 1ps
module tb_md5_udp_verify_key_unit;
    import mvk_pkg::*;

    // Predicted key for one address under one secret: single-block MD5 of the
    // 8-byte word {secret, ip}, digest words XORed, mod 0xFFFFFFFE, plus one.
    function automatic logic [31:0] predict_verify_key(input logic [31:0] ip,
                                                       input logic [31:0] secret);
        logic [31:0] hash_a, hash_b, hash_c, hash_d, mix, sum, word, tmp, fold;
        logic [63:0] dbl;
        int unsigned step, sel;
        hash_a = InitA;
        hash_b = InitB;
        hash_c = InitC;
        hash_d = InitD;
        for (step = 0; step < 64; step++) begin
            if (step < 16) begin
                mix = (hash_b & hash_c) | (~hash_b & hash_d);
                sel = step;
            end else if (step < 32) begin
                mix = (hash_d & hash_b) | (~hash_d & hash_c);
                sel = (5 * step + 1) % 16;
            end else if (step < 48) begin
                mix = hash_b ^ hash_c ^ hash_d;
                sel = (3 * step + 5) % 16;
            end else begin
                mix = hash_c ^ (hash_b | ~hash_d);
                sel = (7 * step) % 16;
            end
            case (sel)
                0: word = ip;
                1: word = secret;
                2: word = PadWord;
                14: word = MsgBits;
                default: word = '0;
            endcase
            sum = hash_a + mix + RoundK[step] + word;
            dbl = {sum, sum} << RoundRot[((step / 16) * 4) + (step % 4)];
            tmp = hash_d;
            hash_d = hash_c;
            hash_c = hash_b;
            hash_b = hash_b + dbl[63:32];
            hash_a = tmp;
        end
        fold = (hash_a + InitA) ^ (hash_b + InitB) ^ (hash_c + InitC) ^ (hash_d + InitD);
        return (fold % KeyModulus) + 32'd1;
    endfunction

    // Scoreboard: expected keys in request order.
    class key_scoreboard;
        logic [31:0] pending_keys[$];
        int          n_errors;
        int          n_checked;

        function void note_request(input logic [31:0] ip, input logic [31:0] secret);
            pending_keys.push_back(predict_verify_key(ip, secret));
        endfunction

        function void check_key(input logic [31:0] got);
            logic [31:0] want;
            if (pending_keys.size() == 0) begin
                $display("%0t: unexpected key, expected none, actual %h", $time, got);
                n_errors++;
                return;
            end
            want = pending_keys.pop_front();
            n_checked++;
            if (want !== got) begin
                $display("%0t: verify_key expected %h actual %h", $time, want, got);
                n_errors++;
            end
        endfunction
    endclass

    localparam int Latency = 66;
    localparam int IdleLimit = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_target_ip;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_verify_key;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_secret_key;

    key_scoreboard keys;
    logic [31:0]   secret_model;  // mirror of the block's secret_key register
    int            send_idle_pct; // percent of cycles the sender holds off
    int            recv_stall_pct;
    int            idle_cycles;
    int            n_requests;

    md5_udp_verify_key_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_target_ip     (i_target_ip),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_verify_key    (o_verify_key),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_secret_key(i_cfg_secret_key)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: check keys on accepted edges, then redraw the stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            keys.check_key(o_verify_key);
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog: no progress in %0d cycles", IdleLimit);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Send one address; honors the sender idle ratio before raising valid.
    // Valid stays high on return so back-to-back sends drive it once per edge
    // while o_stall is low; the caller drops it when the burst ends.
    task automatic send_ip(input logic [31:0] ip);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_target_ip <= $urandom;  // don't-care value while idle
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_target_ip <= ip;
        do @(posedge i_clk); while (o_stall);
        keys.note_request(ip, secret_model);
        n_requests++;
    endtask

    // Register write only with the pipe drained.
    task automatic write_secret(input logic [31:0] value);
        i_valid <= 1'b0;
        while (keys.pending_keys.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_secret_key <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        secret_model = value;
    endtask

    task automatic random_ips(input int count);
        int k;
        logic [31:0] ip;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(3))
                0: ip = {8'd192, 8'd168, 8'($urandom_range(255)), 8'($urandom_range(255))};
                1: ip = ~($urandom_range(255));
                default: ip = $urandom;
            endcase
            send_ip(ip);
        end
    endtask

    initial begin
        keys = new();
        secret_model = '0;
        n_requests = 0;
        send_idle_pct = 16;
        recv_stall_pct = 74;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_target_ip = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_secret_key = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes and single bits under the reset secret, then two written secrets, then random.
        send_ip(32'h0000_0000);
        send_ip(32'hFFFF_FFFF);
        send_ip(32'h8000_0000);
        send_ip(32'h0000_0001);
        send_ip(32'h5555_5555);
        send_ip(32'hAAAA_AAAA);
        send_ip(32'hC0A8_0001);
        write_secret(32'hFFFF_FFFF);
        send_ip(32'h0000_0000);
        send_ip(32'hFFFF_FFFF);
        send_ip(32'h7F00_0001);
        write_secret(32'h8000_0001);
        send_ip(32'h0A00_0001);
        send_ip(32'h1234_5678);
        random_ips(150);

        // Reversed idling: sender sparse, receiver mostly ready.
        send_idle_pct = 74;
        recv_stall_pct = 16;
        write_secret($urandom);
        random_ips(150);

        // Full rate both sides under the reset-value secret, then under a random one.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_secret(32'h0000_0000);
        random_ips(100);
        write_secret($urandom);
        random_ips(100);

        i_valid <= 1'b0;
        while (keys.pending_keys.size() != 0) @(posedge i_clk);
        repeat (Latency + 4) @(posedge i_clk);
        $display("Sent %0d addresses under 6 secrets (both extremes); %0d keys checked.",
                 n_requests, keys.n_checked);
        if (keys.n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
